@@ design/ufd_pkg.sv @@
package ufd_pkg;

   // ascii codes the decoder looks for
   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_PLUS    = 8'h2B;
   localparam logic [7:0] CHAR_PERCENT = 8'h25;

   // status codes carried on the result channel
   typedef enum logic [1:0] {
      STATUS_OK      = 2'd0,
      STATUS_SHORT   = 2'd1,
      STATUS_BAD_HEX = 2'd2
   } status_type;

   // one result item
   typedef struct packed {
      logic [7:0] out_byte;
      logic       has_byte;
      logic [5:0] space_count;
      status_type status;
      logic       end_of_string;
   } result_type;

   // hex digit lookup: bit 4 set when the character is a hex digit
   function automatic logic [4:0] hex_digit(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end
      return r;
   endfunction

endpackage

@@ design/url_form_decoder.sv @@
// channel   direction  handshake               payload
// req       in         req_valid / req_stall   req_in_byte, req_in_last
// rsp       out        rsp_valid / rsp_stall   rsp_out_byte, rsp_has_byte, rsp_space_count,
//                                              rsp_status, rsp_end_of_string
// csr       in         csr_wr_en               csr_wr_data (trim_spaces)
//
// one request per clock while req_stall is low; its result, if any, shows on rsp in the cycle after acceptance
// when nothing waits ahead of it, later while rsp is stalled.
// all decoding is one combinational pass between the string state and the result register.
// reset (synchronous, active high) clears string state, trim_spaces and both result slots.
// a result register plus one skid slot keep requests flowing while rsp is stalled;
// req_stall rises only once the skid slot is full, and it comes straight from a flop.
module url_form_decoder #(
   parameter int SPACE_RUN_MAX = 63
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_in_byte,
   input  logic       req_in_last,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_has_byte,
   output logic [5:0] rsp_space_count,
   output logic [1:0] rsp_status,
   output logic       rsp_end_of_string,
   input  logic       csr_wr_en,
   input  logic       csr_wr_data
);
   import ufd_pkg::*;

   // held run length at which an early flush happens
   localparam logic [6:0] SpaceCap = 7'((SPACE_RUN_MAX > 63) ? 63 :
                                        ((SPACE_RUN_MAX < 1) ? 1 : SPACE_RUN_MAX));

   typedef enum logic [1:0] {
      PHASE_PLAIN = 2'd0,
      PHASE_HIGH  = 2'd1,
      PHASE_LOW   = 2'd2
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [3:0] nibble_ff, nibble_in;
   logic       leading_ff, leading_in;
   logic [5:0] held_ff, held_in;
   status_type error_ff, error_in;
   logic       trim_ff;

   result_type rsp_ff, rsp_in;
   logic       rsp_valid_ff;
   result_type skid_ff;
   logic       skid_valid_ff;

   logic       in_fire;
   logic       out_take;
   logic       emit;
   logic       new_err;
   status_type err_code;
   logic [4:0] hex;
   logic [6:0] held_inc;

   assign in_fire  = req_valid && !req_stall;
   assign out_take = rsp_valid_ff && !rsp_stall;
   assign hex      = hex_digit(req_in_byte);
   assign held_inc = {1'b0, held_ff} + 7'd1;

   // decode one request against the string state
   always_comb begin
      phase_in   = phase_ff;
      nibble_in  = nibble_ff;
      leading_in = leading_ff;
      held_in    = held_ff;
      error_in   = error_ff;
      emit       = 1'b0;
      new_err    = 1'b0;
      err_code   = STATUS_OK;
      rsp_in     = '0;
      rsp_in.status = STATUS_OK;
      if (error_ff == STATUS_OK) begin
         unique case (phase_ff)
            PHASE_PLAIN: begin
               if (req_in_byte == CHAR_SPACE && trim_ff) begin
                  // literal space: drop at start and at end of string, otherwise hold it
                  if (!leading_ff && !req_in_last) begin
                     if (held_inc >= SpaceCap) begin
                        emit               = 1'b1;
                        rsp_in.space_count = held_inc[5:0];
                        held_in            = 6'd0;
                     end else begin
                        held_in = held_inc[5:0];
                     end
                  end
               end else begin
                  leading_in = 1'b0;
                  if (req_in_byte == CHAR_PERCENT) begin
                     phase_in = PHASE_HIGH;
                  end else begin
                     emit               = 1'b1;
                     rsp_in.has_byte    = 1'b1;
                     rsp_in.out_byte    = (req_in_byte == CHAR_PLUS) ? CHAR_SPACE : req_in_byte;
                     rsp_in.space_count = held_ff;
                     held_in            = 6'd0;
                  end
               end
            end
            PHASE_HIGH, PHASE_LOW: begin
               if (!hex[4]) begin
                  new_err  = 1'b1;
                  err_code = STATUS_BAD_HEX;
               end else if (phase_ff == PHASE_HIGH) begin
                  nibble_in = hex[3:0];
                  phase_in  = PHASE_LOW;
               end else begin
                  emit               = 1'b1;
                  rsp_in.has_byte    = 1'b1;
                  rsp_in.out_byte    = {nibble_ff, hex[3:0]};
                  rsp_in.space_count = held_ff;
                  held_in            = 6'd0;
                  phase_in           = PHASE_PLAIN;
               end
            end
            default: begin
               phase_in = PHASE_PLAIN;
            end
         endcase
         // escape still open at end of string
         if (!new_err && req_in_last && phase_in != PHASE_PLAIN) begin
            new_err  = 1'b1;
            err_code = STATUS_SHORT;
         end
         if (new_err) begin
            error_in = err_code;
            held_in  = 6'd0;
            phase_in = PHASE_PLAIN;
            emit     = 1'b1;
            rsp_in   = '0;
            rsp_in.status = err_code;
         end
      end
      // closing result and string restart
      if (req_in_last) begin
         emit                 = 1'b1;
         rsp_in.status        = error_in;
         rsp_in.end_of_string = 1'b1;
         phase_in             = PHASE_PLAIN;
         nibble_in            = 4'd0;
         leading_in           = 1'b1;
         held_in              = 6'd0;
         error_in             = STATUS_OK;
      end
   end

   // string state, config, result register and skid slot
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PHASE_PLAIN;
         nibble_ff     <= 4'd0;
         leading_ff    <= 1'b1;
         held_ff       <= 6'd0;
         error_ff      <= STATUS_OK;
         trim_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            trim_ff <= csr_wr_data;
         end
         if (in_fire) begin
            phase_ff   <= phase_in;
            nibble_ff  <= nibble_in;
            leading_ff <= leading_in;
            held_ff    <= held_in;
            error_ff   <= error_in;
         end
         if (!rsp_valid_ff || out_take) begin
            if (skid_valid_ff) begin
               rsp_ff        <= skid_ff;
               rsp_valid_ff  <= 1'b1;
               skid_valid_ff <= 1'b0;
            end else begin
               rsp_ff       <= rsp_in;
               rsp_valid_ff <= in_fire && emit;
            end
         end else if (in_fire && emit) begin
            skid_ff       <= rsp_in;
            skid_valid_ff <= 1'b1;
         end
      end
   end

   assign req_stall         = skid_valid_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_out_byte      = rsp_ff.out_byte;
   assign rsp_has_byte      = rsp_ff.has_byte;
   assign rsp_space_count   = rsp_ff.space_count;
   assign rsp_status        = rsp_ff.status;
   assign rsp_end_of_string = rsp_ff.end_of_string;

   // skid slot only fills behind a waiting result
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid slot full while result register empty");

   // a stalled result is never dropped
   a_rsp_held: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff)
      else $error("stalled result lost");

   // held run stays below the flush limit
   a_held_cap: assert property (@(posedge clock) disable iff (reset)
      {1'b0, held_ff} < SpaceCap)
      else $error("held space count reached flush limit");

   // after an error nothing is pending
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      error_ff != STATUS_OK |-> phase_ff == PHASE_PLAIN && held_ff == 6'd0)
      else $error("escape or spaces pending after error");

   // end of string restarts the string state
   a_last_restart: assert property (@(posedge clock) disable iff (reset)
      in_fire && req_in_last |=> leading_ff && error_ff == STATUS_OK
                                 && phase_ff == PHASE_PLAIN)
      else $error("string state not restarted after last request");

endmodule

@@ tb/url_form_decoder_tb.sv @@
module url_form_decoder_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import ufd_pkg::*;

   localparam int SPACE_RUN_MAX = 63;
   localparam int SPACE_CAP     = (SPACE_RUN_MAX > 63) ? 63 :
                                  ((SPACE_RUN_MAX < 1) ? 1 : SPACE_RUN_MAX);
   localparam int IDLE_PCT      = 16;
   localparam int PHASE_ITEMS   = 500;
   localparam int CYCLE_LIMIT   = 400000;

   typedef enum logic [1:0] {
      ESC_NONE = 2'd0,
      ESC_HIGH = 2'd1,
      ESC_LOW  = 2'd2
   } esc_phase_type;

   typedef struct {
      logic       trim;
      logic [7:0] code;
      logic       last;
      bit         typed;
      result_type want;
   } directed_row_type;

   logic       clock;
   logic       reset       = 1'b1;
   logic       req_valid   = 1'b0;
   logic       req_stall;
   logic [7:0] req_in_byte = 8'h00;
   logic       req_in_last = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall   = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_has_byte;
   logic [5:0] rsp_space_count;
   logic [1:0] rsp_status;
   logic       rsp_end_of_string;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   // typed-in expectation travels with the request like its payload
   bit         req_typed = 1'b0;
   result_type req_given = '0;

   // decoder state as the testbench sees it
   logic          trim_on       = 1'b0;
   esc_phase_type esc_phase     = ESC_NONE;
   logic [3:0]    hi_nibble     = 4'd0;
   logic          leading_run   = 1'b1;
   int            held_spaces   = 0;
   status_type    sticky_status = STATUS_OK;

   bit               idle_on     = 1'b1;
   int               failures    = 0;
   int               cycle_count = 0;
   result_type       pending_results[$];
   directed_row_type directed_rows[$];

   url_form_decoder #(
      .SPACE_RUN_MAX(SPACE_RUN_MAX)
   ) DUT (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_in_byte      (req_in_byte),
      .req_in_last      (req_in_last),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_has_byte     (rsp_has_byte),
      .rsp_space_count  (rsp_space_count),
      .rsp_status       (rsp_status),
      .rsp_end_of_string(rsp_end_of_string),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hex digit value, -1 for anything else
   function automatic int digit_value(input logic [7:0] c);
      if (c inside {[8'h30:8'h39]}) return int'(c) - 'h30;
      if (c inside {[8'h41:8'h46]}) return int'(c) - 'h41 + 10;
      if (c inside {[8'h61:8'h66]}) return int'(c) - 'h61 + 10;
      return -1;
   endfunction

   // decode one raw byte, returns 1 when a result comes out
   function automatic bit decode_byte(input logic [7:0] c, input logic last,
                                      output result_type r);
      bit         emit;
      bit         new_err;
      status_type code;
      int         v;
      emit    = 1'b0;
      new_err = 1'b0;
      code    = STATUS_OK;
      r       = '0;
      if (sticky_status == STATUS_OK) begin
         if (esc_phase == ESC_NONE) begin
            if (c == CHAR_SPACE && trim_on) begin
               // literal space: dropped at the start and at the end, held in between
               if (!leading_run && !last) begin
                  held_spaces++;
                  if (held_spaces >= SPACE_CAP) begin
                     emit          = 1'b1;
                     r.space_count = 6'(held_spaces);
                     held_spaces   = 0;
                  end
               end
            end else begin
               leading_run = 1'b0;
               if (c == CHAR_PERCENT) begin
                  esc_phase = ESC_HIGH;
               end else begin
                  emit          = 1'b1;
                  r.has_byte    = 1'b1;
                  r.out_byte    = (c == CHAR_PLUS) ? CHAR_SPACE : c;
                  r.space_count = 6'(held_spaces);
                  held_spaces   = 0;
               end
            end
         end else begin
            v = digit_value(c);
            if (v < 0) begin
               new_err = 1'b1;
               code    = STATUS_BAD_HEX;
            end else if (esc_phase == ESC_HIGH) begin
               hi_nibble = 4'(v);
               esc_phase = ESC_LOW;
            end else begin
               emit          = 1'b1;
               r.has_byte    = 1'b1;
               r.out_byte    = {hi_nibble, 4'(v)};
               r.space_count = 6'(held_spaces);
               held_spaces   = 0;
               esc_phase     = ESC_NONE;
            end
         end
         if (!new_err && last && esc_phase != ESC_NONE) begin
            new_err = 1'b1;
            code    = STATUS_SHORT;
         end
         if (new_err) begin
            sticky_status = code;
            held_spaces   = 0;
            esc_phase     = ESC_NONE;
            emit          = 1'b1;
            r             = '0;
            r.status      = code;
         end
      end
      // closing result and fresh string state
      if (last) begin
         emit            = 1'b1;
         r.status        = sticky_status;
         r.end_of_string = 1'b1;
         esc_phase       = ESC_NONE;
         hi_nibble       = 4'd0;
         leading_run     = 1'b1;
         held_spaces     = 0;
         sticky_status   = STATUS_OK;
      end
      return emit;
   endfunction

   // result check, then prediction of the request taken at this edge
   always @(posedge clock) begin
      result_type want;
      result_type pred;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_results.size() == 0) begin
               $error("unexpected result byte %0h status %0d", rsp_out_byte, rsp_status);
               failures++;
            end else begin
               want = pending_results.pop_front();
               if (rsp_out_byte !== want.out_byte) begin
                  $error("out_byte expected %0h got %0h", want.out_byte, rsp_out_byte);
                  failures++;
               end
               if (rsp_has_byte !== want.has_byte) begin
                  $error("has_byte expected %0d got %0d", want.has_byte, rsp_has_byte);
                  failures++;
               end
               if (rsp_space_count !== want.space_count) begin
                  $error("space_count expected %0d got %0d", want.space_count,
                         rsp_space_count);
                  failures++;
               end
               if (rsp_status !== want.status) begin
                  $error("status expected %0d got %0d", want.status, rsp_status);
                  failures++;
               end
               if (rsp_end_of_string !== want.end_of_string) begin
                  $error("end_of_string expected %0d got %0d", want.end_of_string,
                         rsp_end_of_string);
                  failures++;
               end
            end
         end
         if (req_valid && !req_stall) begin
            if (decode_byte(req_in_byte, req_in_last, pred)) begin
               pending_results.push_back(req_typed ? req_given : pred);
            end
         end
      end
      rsp_stall <= idle_on && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAIL url_form_decoder");
         $finish;
      end
   end

   function automatic void add_row(input logic t, input logic [7:0] c, input logic l,
                                   input bit typed = 1'b0, input logic [7:0] ob = 8'h00,
                                   input logic hb = 1'b0, input logic [5:0] sc = 6'd0,
                                   input status_type st = STATUS_OK,
                                   input logic eos = 1'b0);
      directed_row_type row;
      row.trim               = t;
      row.code               = c;
      row.last               = l;
      row.typed              = typed;
      row.want.out_byte      = ob;
      row.want.has_byte      = hb;
      row.want.space_count   = sc;
      row.want.status        = st;
      row.want.end_of_string = eos;
      directed_rows.push_back(row);
   endfunction

   function automatic logic [7:0] random_hex();
      int v;
      v = $urandom_range(0, 21);
      if (v < 10) return 8'(8'h30 + v);
      if (v < 16) return 8'(8'h41 + v - 10);
      return 8'(8'h61 + v - 16);
   endfunction

   task automatic send_request(input logic [7:0] c, input logic last, input bit typed,
                               input result_type want);
      while (idle_on && $urandom_range(0, 99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_in_byte <= c;
      req_in_last <= last;
      req_typed   <= typed;
      req_given   <= want;
      do @(posedge clock); while (req_stall);
   endtask

   // register write only once the decoder has drained
   task automatic write_trim(input logic v);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      trim_on = v;
   endtask

   // one string: mostly well-formed tokens, some noise and broken escapes
   task automatic send_random_string(output int n);
      logic [7:0] text[$];
      int         tokens;
      int         kind;
      int         len;
      tokens = $urandom_range(1, 8);
      if ($urandom_range(0, 9) == 0) begin
         repeat (tokens) text.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat (tokens) begin
            kind = $urandom_range(0, 99);
            if (kind < 25) begin
               len = (kind < 2) ? $urandom_range(60, 70) : $urandom_range(1, 4);
               repeat (len) text.push_back(CHAR_SPACE);
            end else if (kind < 45) begin
               text.push_back(CHAR_PERCENT);
               text.push_back(random_hex());
               text.push_back(random_hex());
            end else if (kind < 55) begin
               text.push_back(CHAR_PLUS);
            end else if (kind < 60) begin
               text.push_back(CHAR_PERCENT);
               if ($urandom_range(0, 1) == 1) text.push_back(random_hex());
            end else begin
               text.push_back(8'($urandom_range(0, 255)));
            end
         end
      end
      foreach (text[i]) send_request(text[i], i == text.size() - 1, 1'b0, '0);
      n = text.size();
   endtask

   initial begin
      directed_row_type cur;
      int               sent;
      int               n;

      // trim off: byte extremes, plain escape
      add_row(1'b0, 8'h00, 1'b0, 1'b1, 8'h00, 1'b1, 6'd0, STATUS_OK, 1'b0);
      add_row(1'b0, CHAR_PERCENT, 1'b0);
      add_row(1'b0, 8'h34, 1'b0);
      add_row(1'b0, 8'h31, 1'b0);
      add_row(1'b0, 8'hFF, 1'b1, 1'b1, 8'hFF, 1'b1, 6'd0, STATUS_OK, 1'b1);
      // non-hex digit, then the rest of the string is ignored
      add_row(1'b0, CHAR_PERCENT, 1'b0);
      add_row(1'b0, 8'h67, 1'b0, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_BAD_HEX, 1'b0);
      add_row(1'b0, 8'h79, 1'b1, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_BAD_HEX, 1'b1);
      // escape cut short by the end of the string, then a lone plus
      add_row(1'b0, CHAR_PERCENT, 1'b0);
      add_row(1'b0, 8'h61, 1'b1, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_SHORT, 1'b1);
      add_row(1'b0, CHAR_PLUS, 1'b1, 1'b1, CHAR_SPACE, 1'b1, 6'd0, STATUS_OK, 1'b1);
      // trim on: leading space dropped, inner spaces held, trailing ones lost
      add_row(1'b1, CHAR_SPACE, 1'b0);
      add_row(1'b1, 8'h62, 1'b0, 1'b1, 8'h62, 1'b1, 6'd0, STATUS_OK, 1'b0);
      add_row(1'b1, CHAR_SPACE, 1'b0);
      add_row(1'b1, CHAR_SPACE, 1'b0);
      add_row(1'b1, CHAR_PERCENT, 1'b0);
      add_row(1'b1, 8'h46, 1'b0);
      add_row(1'b1, 8'h66, 1'b0);
      add_row(1'b1, CHAR_SPACE, 1'b0);
      add_row(1'b1, CHAR_SPACE, 1'b1, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_OK, 1'b1);
      // literal space inside an escape
      add_row(1'b1, CHAR_PERCENT, 1'b0);
      add_row(1'b1, CHAR_SPACE, 1'b0, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_BAD_HEX, 1'b0);
      add_row(1'b1, CHAR_PLUS, 1'b1, 1'b1, 8'h00, 1'b0, 6'd0, STATUS_BAD_HEX, 1'b1);
      // escaped space is never trimmed
      add_row(1'b1, CHAR_PERCENT, 1'b0);
      add_row(1'b1, 8'h32, 1'b0);
      add_row(1'b1, 8'h30, 1'b1, 1'b1, CHAR_SPACE, 1'b1, 6'd0, STATUS_OK, 1'b1);

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         cur = directed_rows[i];
         if (cur.trim !== trim_on) write_trim(cur.trim);
         send_request(cur.code, cur.last, cur.typed, cur.want);
      end

      // random strings, trim alternating, third phase without idling
      for (int ph = 0; ph < 4; ph++) begin
         write_trim(~ph[0]);
         idle_on = (ph != 2);
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            send_random_string(n);
            sent += n;
         end
      end

      // drain
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failures == 0) begin
         $display("PASS url_form_decoder");
      end else begin
         $display("FAIL url_form_decoder");
      end
      $finish;
   end

endmodule
